>>> rtl/hkrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID boot keyboard report builder package
// Shared types, codes and constants for the report builder and its slot chain.
// ----------------------------------------------------------------------------
package hkrb_pkg;

    // Number of key slots in a boot protocol report.
    localparam int SLOT_MAX = 6;
    localparam int KEY_W    = 8;

    // Operation codes carried by a command beat.
    typedef enum logic [1:0] {
        FUNC_PRESS       = 2'd0,
        FUNC_RELEASE     = 2'd1,
        FUNC_RELEASE_ALL = 2'd2,
        FUNC_SEND        = 2'd3
    } func_t;

    // What a beat travelling down the slot chain asks each slot to do.
    typedef enum logic [1:0] {
        PH_SCAN  = 2'd0,
        PH_WRITE = 2'd1,
        PH_CLEAR = 2'd2
    } phase_t;

    // Input item.
    typedef struct packed {
        func_t            func;
        logic [KEY_W-1:0] key_code;
    } hkrb_cmd_t;

    // Result item.
    typedef struct packed {
        logic [KEY_W-1:0] modifier_mask;
        logic [KEY_W-1:0] key_slot_0;
        logic [KEY_W-1:0] key_slot_1;
        logic [KEY_W-1:0] key_slot_2;
        logic [KEY_W-1:0] key_slot_3;
        logic [KEY_W-1:0] key_slot_4;
        logic [KEY_W-1:0] key_slot_5;
    } hkrb_report_t;

    // Beat handed from one slot cell to the next.
    typedef struct packed {
        logic             valid;
        phase_t           phase;
        logic [KEY_W-1:0] key;
        logic             hit;   // some slot already holds the key
        logic             done;  // the key has been stored
    } hkrb_beat_t;

    // Usages 0xE0 through 0xE7 are the eight modifier keys.
    function automatic logic is_modifier(input logic [KEY_W-1:0] k);
        is_modifier = (k[KEY_W-1:3] == 5'b11100);
    endfunction

endpackage

>>> rtl/hid_keyboard_report_builder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID boot keyboard report builder
// Keeps an 8-bit modifier mask and up to six key slots and emits the current
// boot protocol report on request.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload                  Direction
//  -------   --------------------   ----------------------   ---------
//  command   start / busy           cmd   (hkrb_cmd_t)       in
//  report    report_valid strobe    report (hkrb_report_t)   out
//
// A command beat is taken at a rising edge with start high and busy low.
// Press and release of a modifier, release-all, send and a press of key code
// zero finish in the cycle they are taken; busy stays low and a new command
// may follow in the next cycle. A report appears on report_valid in the cycle
// after its send command and stays for exactly one cycle.
// A press of any other key makes two walks of the slot chain: one beat
// walks it to look for a duplicate, a second beat walks it again to store
// the key. A release of any other key makes one clearing walk. A beat
// moves along the chain one cell per cycle. Reset clears the mask and
// every slot at once; the report side has no back pressure.
//
module hid_keyboard_report_builder_unit #(
    parameter int SLOT_COUNT = hkrb_pkg::SLOT_MAX
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  hkrb_pkg::hkrb_cmd_t    cmd,
    output logic                   busy,
    output logic                   report_valid,
    output hkrb_pkg::hkrb_report_t report
);

    // Beat entering each cell; entry SLOT_COUNT is what leaves the last cell.
    hkrb_pkg::hkrb_beat_t                             beats [SLOT_COUNT+1];
    logic [hkrb_pkg::SLOT_MAX-1:0][hkrb_pkg::KEY_W-1:0] slots;
    logic [SLOT_COUNT:0]                              chain_valid;
    logic                                             clr_all;

    hkrb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .inject       (beats[0]),
        .ret          (beats[SLOT_COUNT]),
        .clr_all      (clr_all),
        .slots        (slots),
        .report_valid (report_valid),
        .report       (report)
    );

    // The slot chain: cell i holds report slot i and passes each beat on to
    // cell i+1 in the following cycle. Slots from SLOT_COUNT upward report as empty.
    genvar gi;
    generate
        for (gi = 0; gi < hkrb_pkg::SLOT_MAX; gi++)
        begin : g_slot
            if (gi < SLOT_COUNT)
            begin : g_cell
                hkrb_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .clr_all  (clr_all),
                    .beat_in  (beats[gi]),
                    .beat_out (beats[gi+1]),
                    .slot     (slots[gi])
                );
            end
            else
            begin : g_empty
                assign slots[gi] = '0;
            end
        end
        for (gi = 0; gi <= SLOT_COUNT; gi++)
        begin : g_valid
            assign chain_valid[gi] = beats[gi].valid;
        end
    endgenerate

    // Only one beat is ever in flight along the chain.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one beat in the slot chain");

    // A beat only travels while a command is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        beats[0].valid |-> busy)
        else $error("beat launched while idle");

    // The block goes idle only when a beat has come back from the chain end.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(beats[SLOT_COUNT].valid))
        else $error("busy dropped before the chain walk finished");

    // Every report is caused by a send command taken in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> $past(start && !busy && (cmd.func == hkrb_pkg::FUNC_SEND)))
        else $error("report strobe without a send command");

endmodule

>>> rtl/hkrb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key slot cell
// Holds one report slot and acts on the beat passing through, then hands the
// beat to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module hkrb_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clr_all,
    input  hkrb_pkg::hkrb_beat_t       beat_in,
    output hkrb_pkg::hkrb_beat_t       beat_out,
    output logic [hkrb_pkg::KEY_W-1:0] slot
);

    logic [hkrb_pkg::KEY_W-1:0] slot_reg;
    logic [hkrb_pkg::KEY_W-1:0] slot_next;
    hkrb_pkg::hkrb_beat_t       beat_reg;
    hkrb_pkg::hkrb_beat_t       beat_next;
    logic                       match;
    logic                       empty;

    assign match = (slot_reg == beat_in.key);
    assign empty = (slot_reg == '0);

    always_comb
    begin
        slot_next = slot_reg;
        beat_next = beat_in;
        if (beat_in.valid)
        begin
            case (beat_in.phase)
                hkrb_pkg::PH_SCAN:
                begin
                    beat_next.hit = beat_in.hit | match;
                end
                hkrb_pkg::PH_WRITE:
                begin
                    // The lowest empty slot takes the key unless it is a duplicate.
                    if (!beat_in.hit && !beat_in.done && empty)
                    begin
                        slot_next      = beat_in.key;
                        beat_next.done = 1'b1;
                    end
                end
                hkrb_pkg::PH_CLEAR:
                begin
                    if (match)
                    begin
                        slot_next = '0;
                    end
                end
                default:
                begin
                    slot_next = slot_reg;
                end
            endcase
        end
        if (clr_all)
        begin
            slot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            beat_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
            beat_reg <= beat_next;
        end
    end

    assign beat_out = beat_reg;
    assign slot     = slot_reg;

endmodule

>>> rtl/hkrb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Report builder controller
// Decodes commands, keeps the modifier mask, launches beats into the slot
// chain and forms the report beat.
// ----------------------------------------------------------------------------
module hkrb_ctrl (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            start,
    input  hkrb_pkg::hkrb_cmd_t                             cmd,
    output logic                                            busy,
    output hkrb_pkg::hkrb_beat_t                            inject,
    input  hkrb_pkg::hkrb_beat_t                            ret,
    output logic                                            clr_all,
    input  logic [hkrb_pkg::SLOT_MAX-1:0][hkrb_pkg::KEY_W-1:0] slots,
    output logic                                            report_valid,
    output hkrb_pkg::hkrb_report_t                          report
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_CLEAR
    } state_t;

    state_t                     state_reg;
    hkrb_pkg::hkrb_beat_t       inject_reg;
    hkrb_pkg::hkrb_beat_t       inject_next;
    logic [hkrb_pkg::KEY_W-1:0] mods_reg;
    logic                       report_valid_reg;
    hkrb_pkg::hkrb_report_t     report_reg;
    logic                       accept;
    logic                       is_mod;

    assign accept  = start && (state_reg == ST_IDLE);
    assign is_mod  = hkrb_pkg::is_modifier(cmd.key_code);
    assign clr_all = accept && (cmd.func == hkrb_pkg::FUNC_RELEASE_ALL);

    // Beat launched into the chain in the next cycle, if any.
    always_comb
    begin
        inject_next = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !is_mod)
                begin
                    if ((cmd.func == hkrb_pkg::FUNC_PRESS) && (cmd.key_code != '0))
                    begin
                        inject_next = '{valid: 1'b1, phase: hkrb_pkg::PH_SCAN,
                                        key: cmd.key_code, hit: 1'b0, done: 1'b0};
                    end
                    else if (cmd.func == hkrb_pkg::FUNC_RELEASE)
                    begin
                        inject_next = '{valid: 1'b1, phase: hkrb_pkg::PH_CLEAR,
                                        key: cmd.key_code, hit: 1'b0, done: 1'b0};
                    end
                end
            end
            ST_SCAN:
            begin
                // The scan result comes back from the end of the chain and
                // rides along with the write beat.
                if (ret.valid)
                begin
                    inject_next = '{valid: 1'b1, phase: hkrb_pkg::PH_WRITE,
                                    key: ret.key, hit: ret.hit, done: 1'b0};
                end
            end
            default:
            begin
                inject_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            inject_reg       <= '0;
            mods_reg         <= '0;
            report_valid_reg <= 1'b0;
            report_reg       <= '0;
        end
        else
        begin
            inject_reg       <= inject_next;
            report_valid_reg <= accept && (cmd.func == hkrb_pkg::FUNC_SEND);
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd.func)
                            hkrb_pkg::FUNC_PRESS:
                            begin
                                if (is_mod)
                                begin
                                    mods_reg[cmd.key_code[2:0]] <= 1'b1;
                                end
                                else if (cmd.key_code != '0)
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            hkrb_pkg::FUNC_RELEASE:
                            begin
                                if (is_mod)
                                begin
                                    mods_reg[cmd.key_code[2:0]] <= 1'b0;
                                end
                                else
                                begin
                                    state_reg <= ST_CLEAR;
                                end
                            end
                            hkrb_pkg::FUNC_RELEASE_ALL:
                            begin
                                mods_reg <= '0;
                            end
                            hkrb_pkg::FUNC_SEND:
                            begin
                                report_reg.modifier_mask <= mods_reg;
                                report_reg.key_slot_0    <= slots[0];
                                report_reg.key_slot_1    <= slots[1];
                                report_reg.key_slot_2    <= slots[2];
                                report_reg.key_slot_3    <= slots[3];
                                report_reg.key_slot_4    <= slots[4];
                                report_reg.key_slot_5    <= slots[5];
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (ret.valid)
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE, ST_CLEAR:
                begin
                    if (ret.valid)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign inject       = inject_reg;
    assign report_valid = report_valid_reg;
    assign report       = report_reg;

endmodule
